@@ rtl/tdpt_pkg.sv @@
// Package for the trial-division prime test block.
// Holds the controller state type and the command/status structs shared by
// the controller and the datapath. No dependencies.
package tdpt_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_TEST
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new value, divisor = 3, square = 9
        logic div_init;  // start a remainder pass for the current divisor
        logic div_step;  // one restoring-division bit step
        logic next_div;  // advance divisor and its square
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic special;        // value is decided without trial division
        logic special_prime;  // the answer for the special case
        logic sq_gt;          // divisor squared exceeds the value
        logic div_last;       // this is the last bit step of the pass
        logic rem_zero;       // remainder of the finished pass is zero
    } t_dp_status;

endpackage

@@ rtl/tdpt_dp.sv @@
// Datapath of the trial-division prime test: value, divisor, running square
// and a bit-serial restoring remainder unit.
// Depends on tdpt_pkg for the command and status structs.
module tdpt_dp
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);
    localparam logic [W-1:0]  FIRST_DIV = W'(3);
    localparam logic [W:0]    FIRST_SQ  = (W+1)'(9);
    localparam logic [CW-1:0] LAST_CNT  = CW'(W - 1);

    logic [W-1:0]  r_value;
    logic [W-1:0]  r_div;
    logic [W:0]    r_sq;
    logic [W-1:0]  r_shift;
    logic [W-1:0]  r_rem;
    logic [CW-1:0] r_cnt;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;
    logic [W-1:0]  n_rem;

    // The remainder always stays below the divisor, so one compare and
    // subtract per bit keeps it in range.
    assign trial = {r_rem, r_shift[W-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};
    assign n_rem = ge ? diff[W-1:0] : trial[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_value <= i_value;
                r_div   <= FIRST_DIV;
                r_sq    <= FIRST_SQ;
            end
            if (i_cmd.div_init) begin
                r_shift <= r_value;
                r_rem   <= '0;
                r_cnt   <= '0;
            end
            if (i_cmd.div_step) begin
                r_shift <= {r_shift[W-2:0], 1'b0};
                r_rem   <= n_rem;
                r_cnt   <= r_cnt + 1'b1;
            end
            if (i_cmd.next_div) begin
                // (d+1)^2 = d^2 + 2d + 1
                r_sq  <= r_sq + {r_div, 1'b1};
                r_div <= r_div + 1'b1;
            end
        end
    end

    always_comb begin
        o_status.special       = r_value[W-1] || (r_value <= W'(1)) || !r_value[0];
        o_status.special_prime = (r_value == W'(2));
        o_status.sq_gt         = r_sq > {1'b0, r_value};
        o_status.div_last      = (r_cnt == LAST_CNT);
        o_status.rem_zero      = (r_rem == '0);
    end

endmodule

@@ rtl/tdpt_ctrl.sv @@
// Controller of the trial-division prime test: sequences the square check,
// the remainder passes and the result strobe.
// Depends on tdpt_pkg for the state type and command/status structs.
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_done,
    output logic       o_is_prime
);

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;
    logic   r_is_prime;
    logic   n_is_prime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_is_prime <= n_is_prime;
    end

    always_comb begin
        n_state    = r_state;
        n_done     = 1'b0;
        n_is_prime = r_is_prime;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (i_status.special) begin
                    n_done     = 1'b1;
                    n_is_prime = i_status.special_prime;
                    n_state    = ST_IDLE;
                end else if (i_status.sq_gt) begin
                    n_done     = 1'b1;
                    n_is_prime = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_TEST;
                end
            end
            ST_TEST: begin
                if (i_status.rem_zero) begin
                    n_done     = 1'b1;
                    n_is_prime = 1'b0;
                    n_state    = ST_IDLE;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = ST_CHECK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_done     = r_done;
    assign o_is_prime = r_is_prime;

endmodule

@@ rtl/trial_division_prime_test_top.sv @@
// Trial-division prime test: takes a signed integer and strobes one flag
// that says whether it is prime.
// Depends on tdpt_pkg, tdpt_ctrl and tdpt_dp.
//
// Usage: drive i_value and raise start while busy is low; that edge takes
// the beat and busy rises on the next cycle. When the answer is known,
// o_done is high for exactly one cycle with o_is_prime valid; the receiver
// has no way to hold it off. busy falls in that same cycle, so a new start
// may be given while the result is on the ports.
// Negative values, 0, 1 and even values are settled in ST_CHECK without
// trial division. An odd value v of 3 or more is tested against every
// integer divisor from 3 up, at most floor(sqrt(v)) - 2 of them, until the
// divisor square exceeds v (prime) or a remainder of zero ends the search.
// Each divisor costs one bit-serial remainder pass over the VALUE_WIDTH bits
// of the value plus a square check and a zero test; the divisor square is
// kept by adds. For a 31-bit prime at VALUE_WIDTH = 32 up to 46338 divisors
// are tried. One item is worked on at a time. Synchronous active-low reset
// returns the controller to idle and clears the strobe.
module trial_division_prime_test_top
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_done,
    output logic                   o_is_prime
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    tdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_done     (o_done),
        .o_is_prime (o_is_prime)
    );

    tdpt_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_value),
        .i_cmd    (dp_cmd),
        .o_status (dp_status)
    );

endmodule
